// ===== sv/tbo_pkg.sv =====
// Shared types and constants for the time-bar OHLCV aggregator.
// Used by tbo_bar_accum, tbo_divider and time_bar_ohlcv_aggregator; no dependencies.
package tbo_pkg;

  localparam int TIME_W  = 32;
  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int TCNT_W  = 16;
  localparam int AVG_W   = 32;

  localparam logic [31:0] INTERVAL_RESET = 32'd60;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  // Contents of a closed bar, less count and price sum
  typedef struct packed {
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [SUM_W-1:0]   volume;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
  } bar_snap_t;

  // Bar close event from the accumulator
  typedef struct packed {
    logic      emit;
    bar_snap_t bar;
  } bar_emit_t;

endpackage

// ===== sv/tbo_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the bar average price.
// Depends on tbo_pkg for the dividend width.
module tbo_divider #(
  parameter int DIVISOR_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tbo_pkg::SUM_W-1:0]  dividend,
  input  logic [DIVISOR_BITS-1:0]    divisor,
  output logic                       busy,
  output logic                       done,
  output logic [tbo_pkg::SUM_W-1:0]  quotient
);
  import tbo_pkg::*;

  localparam int STEPS  = SUM_W;
  localparam int STEP_W = $clog2(STEPS);

  logic [STEP_W-1:0]       step;
  logic [SUM_W-1:0]        quo;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] rem_next;
  logic [DIVISOR_BITS-1:0] divisor_q;
  logic                    div_zero;
  logic [DIVISOR_BITS:0]   trial;
  logic                    q_bit;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    q_bit    = (trial >= {1'b0, divisor_q});
    rem_next = q_bit ? DIVISOR_BITS'(trial - {1'b0, divisor_q}) : trial[DIVISOR_BITS-1:0];
  end

  // Control: busy while the quotient bits are worked out, done pulses once
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(STEPS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
      div_zero  <= (divisor == '0);
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  // An empty bar averages to zero
  assign quotient = div_zero ? '0 : quo;

endmodule

// ===== sv/tbo_bar_accum.sv =====
// Open-bar state: interval split decision and folding of one trade per transaction.
// Depends on tbo_pkg for field widths and the bar event struct.
module tbo_bar_accum #(
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [tbo_pkg::TIME_W-1:0]  trade_time,
  input  logic [tbo_pkg::PRICE_W-1:0] trade_price,
  input  logic [tbo_pkg::VOL_W-1:0]   trade_volume,
  input  logic [31:0]                 interval_length,
  output tbo_pkg::bar_emit_t          bar_event,
  output logic [COUNT_BITS-1:0]       count_q,
  output logic [tbo_pkg::SUM_W-1:0]   price_sum_q
);
  import tbo_pkg::*;

  logic [TIME_W-1:0]     interval_start;
  bar_snap_t             bar;
  logic [COUNT_BITS-1:0] count;
  logic [SUM_W-1:0]      price_sum;

  logic [TIME_W-1:0]     start_eff;
  logic                  take;
  logic                  split;
  logic                  emit;
  bar_snap_t             base_bar;
  logic [COUNT_BITS-1:0] base_count;
  logic [SUM_W-1:0]      base_price_sum;
  bar_snap_t             bar_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [SUM_W-1:0]      price_sum_next;
  logic [SUM_W:0]        vol_add;
  logic [SUM_W:0]        price_add;

  // Decide whether this trade opens a new interval
  always_comb begin
    take      = accept && (trade_time != '0);
    start_eff = (interval_start == '0) ? trade_time : interval_start;
    split     = take && (trade_time >= start_eff) &&
                ((trade_time - start_eff) >= interval_length);
    emit      = split && (bar.volume != '0);
  end

  // Fold the trade into the open bar, or into a cleared one after an emission
  always_comb begin
    base_bar       = emit ? '0 : bar;
    base_count     = emit ? '0 : count;
    base_price_sum = emit ? '0 : price_sum;
    bar_next       = base_bar;
    if (base_count == '0) begin
      bar_next.open_price = trade_price;
      bar_next.low_price  = trade_price;
      bar_next.high_price = trade_price;
      bar_next.start_time = trade_time;
    end else begin
      if (trade_price > base_bar.high_price) bar_next.high_price = trade_price;
      if (trade_price < base_bar.low_price)  bar_next.low_price  = trade_price;
    end
    bar_next.close_price = trade_price;
    bar_next.end_time    = trade_time;
    vol_add   = {1'b0, base_bar.volume} + (SUM_W + 1)'(trade_volume);
    price_add = {1'b0, base_price_sum} + (SUM_W + 1)'(trade_price);
    bar_next.volume = vol_add[SUM_W] ? SUM_MAX : vol_add[SUM_W-1:0];
    price_sum_next  = price_add[SUM_W] ? SUM_MAX : price_add[SUM_W-1:0];
    count_next      = (base_count == '1) ? base_count : base_count + 1'b1;
  end

  // Advance the bar state on every trade with a nonzero timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_start <= '0;
      bar            <= '0;
      count          <= '0;
      price_sum      <= '0;
    end else if (take) begin
      if (interval_start == '0 || split) interval_start <= trade_time;
      bar       <= bar_next;
      count     <= count_next;
      price_sum <= price_sum_next;
    end
  end

  assign bar_event.emit = emit;
  assign bar_event.bar  = bar;
  assign count_q        = count;
  assign price_sum_q    = price_sum;

endmodule

// ===== sv/time_bar_ohlcv_aggregator.sv =====
// Top level of the time-bar OHLCV aggregator: sequencer, output register, config.
// Depends on tbo_pkg, tbo_bar_accum and tbo_divider.
//
//   channel   handshake            payload
//   trade in  in_valid / in_ready  trade_time, trade_price, trade_volume
//   bar out   out_valid/out_ready  open..close_price, bar_volume, times, count, avg
//   config    cfg_we               cfg_wdata -> interval_length
//
// A trade that closes a nonempty bar is accepted, then the shared divider
// works out the average (one quotient bit per cycle over the 48-bit price
// sum), and then the output register is loaded; no trade is taken meanwhile.
// The next trade is taken while a finished bar waits in the output register;
// the sequencer holds if a second bar is ready before the first is taken.
// Synchronous reset clears the bar state, sets interval 60.
module time_bar_ohlcv_aggregator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tbo_pkg::TIME_W-1:0]  trade_time,
  input  logic [tbo_pkg::PRICE_W-1:0] trade_price,
  input  logic [tbo_pkg::VOL_W-1:0]   trade_volume,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tbo_pkg::PRICE_W-1:0] open_price,
  output logic [tbo_pkg::PRICE_W-1:0] high_price,
  output logic [tbo_pkg::PRICE_W-1:0] low_price,
  output logic [tbo_pkg::PRICE_W-1:0] close_price,
  output logic [tbo_pkg::SUM_W-1:0]   bar_volume,
  output logic [tbo_pkg::TIME_W-1:0]  bar_start_time,
  output logic [tbo_pkg::TIME_W-1:0]  bar_end_time,
  output logic [tbo_pkg::TCNT_W-1:0]  bar_trade_count,
  output logic [tbo_pkg::AVG_W-1:0]   average_price,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_wdata
);
  import tbo_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [31:0]           interval_length;
  logic                  accept;
  bar_emit_t             bar_event;
  logic [COUNT_BITS-1:0] count_q;
  logic [SUM_W-1:0]      price_sum_q;
  bar_snap_t             snap_hold;
  logic [COUNT_BITS-1:0] count_hold;
  logic                  div_busy;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;
  logic                  out_free;
  logic                  load_out;
  logic [31:0]           count_ext;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length <= INTERVAL_RESET;
    end else if (cfg_we) begin
      interval_length <= cfg_wdata;
    end
  end

  tbo_bar_accum #(
    .COUNT_BITS(COUNT_BITS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .trade_time     (trade_time),
    .trade_price    (trade_price),
    .trade_volume   (trade_volume),
    .interval_length(interval_length),
    .bar_event      (bar_event),
    .count_q        (count_q),
    .price_sum_q    (price_sum_q)
  );

  tbo_divider #(
    .DIVISOR_BITS(COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (bar_event.emit),
    .dividend(price_sum_q),
    .divisor (count_q),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quotient)
  );

  // Hold the closed bar while its average is worked out
  always_ff @(posedge clk) begin
    if (bar_event.emit) begin
      snap_hold  <= bar_event.bar;
      count_hold <= count_q;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (bar_event.emit) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_DIVIDE: load_out = div_done && out_free;
      ST_HOLD:   load_out = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign count_ext = 32'(count_hold);

  // Output register: payload, with saturated count and average
  always_ff @(posedge clk) begin
    if (load_out) begin
      open_price      <= snap_hold.open_price;
      high_price      <= snap_hold.high_price;
      low_price       <= snap_hold.low_price;
      close_price     <= snap_hold.close_price;
      bar_volume      <= snap_hold.volume;
      bar_start_time  <= snap_hold.start_time;
      bar_end_time    <= snap_hold.end_time;
      bar_trade_count <= (count_ext > 32'h0000_FFFF) ? {TCNT_W{1'b1}} : count_ext[TCNT_W-1:0];
      average_price   <= (quotient[SUM_W-1:AVG_W] != '0) ? {AVG_W{1'b1}} :
                         quotient[AVG_W-1:0];
    end
  end

  // A result is loaded only once the divider has finished
  assert property (@(posedge clk) disable iff (rst) load_out |-> !div_busy)
    else $error("output loaded while divider busy");

  // A bar close always starts the divider
  assert property (@(posedge clk) disable iff (rst) bar_event.emit |=> div_busy)
    else $error("bar close did not start divider");

  // The sequencer holds only because the output register is occupied
  assert property (@(posedge clk) disable iff (rst) (state == ST_HOLD) |-> out_valid)
    else $error("holding with empty output register");

endmodule
